// File: rtl/core/tlfd_pkg.sv
// ----------------------------------------------------------------------------
// tlfd_pkg
// shared types and constants of the thick line framebuffer drawer
// ----------------------------------------------------------------------------
package tlfd_pkg;

    localparam int unsigned CoordW = 9;
    localparam int unsigned ChanW  = 8;
    localparam int unsigned BrushW = 4;
    localparam int unsigned PixW   = 3 * ChanW;
    localparam int unsigned SumW   = 19;  // dr*dr + dc*dc for 9-bit coordinates
    localparam int unsigned RootW  = 10;  // ceil(sqrt(SumW bits))
    localparam int unsigned StepW  = 18;  // signed q1.16
    localparam int unsigned NumW   = SumW + 32;  // d*d*2^32
    localparam int unsigned QuoW   = 34;  // quotient d*d*2^32/S <= 2^32
    localparam int unsigned SqW    = 18;  // root of quotient, up to 2^16

    typedef enum logic [1:0] {
        KIND_SET  = 2'd0,
        KIND_LINE = 2'd1,
        KIND_FILL = 2'd2,
        KIND_READ = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT_S,
        ST_DIV_R,
        ST_SQRT_R,
        ST_DIV_C,
        ST_SQRT_C,
        ST_WALK,
        ST_FILL,
        ST_CLEAR,
        ST_READ,
        ST_READ_WAIT,
        ST_OUT
    } state_t;

    // control from the sequencer to the shared divide / root unit
    typedef struct packed {
        logic start_div;
        logic start_sqrt;
    } au_ctrl_t;

endpackage

// File: rtl/core/thick_line_framebuffer_drawer_top.sv
// ----------------------------------------------------------------------------
// thick_line_framebuffer_drawer_top
// rgb framebuffer with pixel set, fill, read and thick line draw commands
// ----------------------------------------------------------------------------
// After reset the block clears the whole canvas one pixel a cycle and
// takes no item meanwhile. A read pixel passes the read, read-wait and
// output states and waits on the output; fill writes one pixel a cycle.
// A line runs one shared bit-serial unit for a square root of the
// squared length and for a divide and a root per axis, then writes one
// pixel a cycle for every step of every brush offset, bound by the
// single framebuffer write port.
module thick_line_framebuffer_drawer_top
#(
    parameter int unsigned CANVAS_ROWS = 512,
    parameter int unsigned CANVAS_COLS = 512,
    parameter int unsigned MAX_BRUSH   = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row_a[8:0] col_a[17:9] row_b[26:18] col_b[35:27]
    // red[43:36] green[51:44] blue[59:52] brush_width[63:60]
    input  logic [63:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_red[7:0] read_green[15:8] read_blue[23:16]
    output logic [23:0] m_tdata
);

    localparam int unsigned CW    = tlfd_pkg::CoordW;
    localparam int unsigned RowW  = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
    localparam int unsigned ColW  = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
    localparam int unsigned Depth = CANVAS_ROWS * CANVAS_COLS;
    localparam int unsigned AddrW = $clog2(Depth);
    localparam int unsigned PosW  = 30;   // signed q.16 positions
    localparam int unsigned HalfW = 6;
    localparam int unsigned OffW  = HalfW + 1;
    localparam int unsigned MaxB  = (MAX_BRUSH > 15) ? 15 : MAX_BRUSH;
    localparam int unsigned SqW   = tlfd_pkg::SqW;
    localparam int unsigned RW    = tlfd_pkg::RootW;
    localparam int unsigned SumW  = tlfd_pkg::SumW;

    tlfd_pkg::state_t state_reg, state_next;

    logic [tlfd_pkg::PixW-1:0] mem [Depth];
    logic [tlfd_pkg::PixW-1:0] rd_data_reg;

    logic                      s_fire;
    tlfd_pkg::kind_t           kind_in;
    logic [CW-1:0]             ra_reg, ca_reg, rb_reg, cb_reg;
    logic [tlfd_pkg::PixW-1:0] rgb_reg, out_reg;
    logic [tlfd_pkg::BrushW-1:0] w_in;
    logic [HalfW-1:0]          half_reg;
    logic signed [CW:0]        dr, dc;
    logic signed [SumW-1:0]    dr_x, dc_x;
    logic [SumW-1:0]           dr_sq, dc_sq;
    logic [SumW-1:0]           s_sum;
    logic [SumW:0]             root_sq;
    logic [RW:0]               n_reg;
    logic [SqW-1:0]            sr_mag_reg, sc_mag_reg;
    logic [AddrW:0]            addr_cnt_reg;
    logic signed [OffW-1:0]    br_reg, bc_reg;
    logic [RW:0]               k_reg;
    logic signed [PosW-1:0]    vr_reg, vc_reg, sr_s, sc_s;
    logic signed [PosW-1:0]    tr, tc;
    logic                      wr_en;
    logic [AddrW-1:0]          wr_addr, rd_addr;
    logic [tlfd_pkg::PixW-1:0] wr_data;

    tlfd_pkg::au_ctrl_t         au_ctrl;
    logic [tlfd_pkg::NumW-1:0]  au_a;
    logic                       au_busy, au_busy_d;
    logic [tlfd_pkg::QuoW-1:0]  au_res;
    logic                       au_done;

    assign s_fire  = s_tvalid && s_tready;
    assign kind_in = tlfd_pkg::kind_t'(s_tuser);
    assign w_in    = s_tdata[63:60];
    assign dr      = $signed({1'b0, ra_reg}) - $signed({1'b0, rb_reg});
    assign dc      = $signed({1'b0, ca_reg}) - $signed({1'b0, cb_reg});
    assign dr_x    = {{(SumW-CW-1){dr[CW]}}, dr};
    assign dc_x    = {{(SumW-CW-1){dc[CW]}}, dc};
    assign dr_sq   = dr_x * dr_x;
    assign dc_sq   = dc_x * dc_x;
    assign s_sum   = dr_sq + dc_sq;
    assign root_sq = (SumW+1)'(au_res[RW-1:0]) * (SumW+1)'(au_res[RW-1:0]);
    assign au_done = au_busy_d && !au_busy;

    tlfd_arith u_arith
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (au_ctrl),
        .op_a   (au_a),
        .op_b   (s_sum),
        .busy   (au_busy),
        .result (au_res)
    );

    function automatic logic signed [PosW-1:0] trunc16(logic signed [PosW-1:0] v);
        logic signed [PosW-1:0] m;
        m = v[PosW-1] ? -v : v;
        m = m >>> 16;
        return v[PosW-1] ? -m : m;
    endfunction

    assign tr = trunc16(vr_reg);
    assign tc = trunc16(vc_reg);
    assign sr_s = dr[CW] ? -$signed({{(PosW-SqW){1'b0}}, sr_mag_reg})
                         : $signed({{(PosW-SqW){1'b0}}, sr_mag_reg});
    assign sc_s = dc[CW] ? -$signed({{(PosW-SqW){1'b0}}, sc_mag_reg})
                         : $signed({{(PosW-SqW){1'b0}}, sc_mag_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlfd_pkg::ST_CLEAR:
                if (addr_cnt_reg == (AddrW+1)'(Depth - 1)) state_next = tlfd_pkg::ST_IDLE;
            tlfd_pkg::ST_IDLE:
                if (s_fire)
                begin
                    unique case (kind_in)
                        tlfd_pkg::KIND_SET:  state_next = tlfd_pkg::ST_IDLE;
                        tlfd_pkg::KIND_LINE: state_next = tlfd_pkg::ST_SQRT_S;
                        tlfd_pkg::KIND_FILL: state_next = tlfd_pkg::ST_FILL;
                        tlfd_pkg::KIND_READ: state_next = tlfd_pkg::ST_READ;
                        default:             state_next = tlfd_pkg::ST_IDLE;
                    endcase
                end
            tlfd_pkg::ST_SQRT_S:
                if (s_sum == '0) state_next = tlfd_pkg::ST_IDLE;
                else if (au_done) state_next = tlfd_pkg::ST_DIV_R;
            tlfd_pkg::ST_DIV_R:  if (au_done) state_next = tlfd_pkg::ST_SQRT_R;
            tlfd_pkg::ST_SQRT_R: if (au_done) state_next = tlfd_pkg::ST_DIV_C;
            tlfd_pkg::ST_DIV_C:  if (au_done) state_next = tlfd_pkg::ST_SQRT_C;
            tlfd_pkg::ST_SQRT_C: if (au_done) state_next = tlfd_pkg::ST_WALK;
            tlfd_pkg::ST_WALK:
                if (k_reg + 1'b1 == n_reg && br_reg == $signed({1'b0, half_reg})
                    && bc_reg == $signed({1'b0, half_reg}))
                    state_next = tlfd_pkg::ST_IDLE;
            tlfd_pkg::ST_FILL:
                if (addr_cnt_reg == (AddrW+1)'(Depth - 1)) state_next = tlfd_pkg::ST_IDLE;
            tlfd_pkg::ST_READ:      state_next = tlfd_pkg::ST_READ_WAIT;
            tlfd_pkg::ST_READ_WAIT: state_next = tlfd_pkg::ST_OUT;
            tlfd_pkg::ST_OUT:       if (m_tready) state_next = tlfd_pkg::ST_IDLE;
            default:                state_next = tlfd_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = 1'b0;
        au_ctrl  = '0;
        au_a     = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = rgb_reg;
        unique case (state_reg)
            tlfd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_fire && kind_in == tlfd_pkg::KIND_SET
                    && 32'(s_tdata[8:0]) < CANVAS_ROWS && 32'(s_tdata[17:9]) < CANVAS_COLS)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AddrW'((CANVAS_ROWS - 1 - 32'(s_tdata[8:0])) * CANVAS_COLS
                                     + 32'(s_tdata[17:9]));
                    wr_data = {s_tdata[43:36], s_tdata[51:44], s_tdata[59:52]};
                end
            end
            tlfd_pkg::ST_SQRT_S:
            begin
                au_a = tlfd_pkg::NumW'(s_sum);
                au_ctrl.start_sqrt = !au_busy && !au_busy_d && s_sum != '0;
            end
            tlfd_pkg::ST_DIV_R, tlfd_pkg::ST_DIV_C:
            begin
                au_a = (state_reg == tlfd_pkg::ST_DIV_R) ? {dr_sq, 32'd0} : {dc_sq, 32'd0};
                au_ctrl.start_div = !au_busy && !au_busy_d;
            end
            tlfd_pkg::ST_SQRT_R, tlfd_pkg::ST_SQRT_C:
            begin
                au_a = tlfd_pkg::NumW'(au_res);
                au_ctrl.start_sqrt = !au_busy && !au_busy_d;
            end
            tlfd_pkg::ST_WALK:
            begin
                if (!tr[PosW-1] && tr < PosW'(CANVAS_ROWS)
                    && !tc[PosW-1] && tc < PosW'(CANVAS_COLS))
                begin
                    wr_en   = 1'b1;
                    wr_addr = AddrW'((CANVAS_ROWS - 1 - RowW'(tr)) * CANVAS_COLS + ColW'(tc));
                end
            end
            tlfd_pkg::ST_FILL, tlfd_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_cnt_reg[AddrW-1:0];
                wr_data = (state_reg == tlfd_pkg::ST_CLEAR) ? '0 : rgb_reg;
            end
            default:;
        endcase
    end

    assign rd_addr = AddrW'((CANVAS_ROWS - 1 - RowW'(ra_reg)) * CANVAS_COLS + ColW'(ca_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tlfd_pkg::ST_CLEAR;
            addr_cnt_reg <= '0;
            au_busy_d    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            au_busy_d <= au_busy;
            if (state_reg == tlfd_pkg::ST_CLEAR || state_reg == tlfd_pkg::ST_FILL)
                addr_cnt_reg <= (state_next == state_reg) ? addr_cnt_reg + 1'b1 : '0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            ra_reg   <= s_tdata[8:0];
            ca_reg   <= s_tdata[17:9];
            rb_reg   <= s_tdata[26:18];
            cb_reg   <= s_tdata[35:27];
            rgb_reg  <= {s_tdata[43:36], s_tdata[51:44], s_tdata[59:52]};
            half_reg <= HalfW'(((w_in > tlfd_pkg::BrushW'(MaxB)) ? tlfd_pkg::BrushW'(MaxB)
                                                                   : w_in) >> 1);
        end
        if (au_done)
        begin
            unique case (state_reg)
                tlfd_pkg::ST_SQRT_S:
                    n_reg <= (RW+1)'(au_res[RW-1:0])
                             + ((root_sq < {1'b0, s_sum}) ? 1'b1 : 1'b0);
                tlfd_pkg::ST_SQRT_R: sr_mag_reg <= SqW'(au_res);
                tlfd_pkg::ST_SQRT_C: sc_mag_reg <= SqW'(au_res);
                default:;
            endcase
        end
        if (state_reg == tlfd_pkg::ST_SQRT_C && au_done)
        begin
            br_reg <= -$signed({1'b0, half_reg});
            bc_reg <= -$signed({1'b0, half_reg});
            k_reg  <= '0;
            vr_reg <= (PosW'(rb_reg) - PosW'(half_reg)) <<< 16;
            vc_reg <= (PosW'(cb_reg) - PosW'(half_reg)) <<< 16;
        end
        else if (state_reg == tlfd_pkg::ST_WALK)
        begin
            if (k_reg + 1'b1 != n_reg)
            begin
                k_reg  <= k_reg + 1'b1;
                vr_reg <= vr_reg + sr_s;
                vc_reg <= vc_reg + sc_s;
            end
            else
            begin
                k_reg <= '0;
                if (bc_reg == $signed({1'b0, half_reg}))
                begin
                    bc_reg <= -$signed({1'b0, half_reg});
                    br_reg <= br_reg + 1'b1;
                    vr_reg <= (PosW'(rb_reg) + PosW'(br_reg) + 1) <<< 16;
                    vc_reg <= (PosW'(cb_reg) - PosW'(half_reg)) <<< 16;
                end
                else
                begin
                    bc_reg <= bc_reg + 1'b1;
                    vr_reg <= (PosW'(rb_reg) + PosW'(br_reg)) <<< 16;
                    vc_reg <= (PosW'(cb_reg) + PosW'(bc_reg) + 1) <<< 16;
                end
            end
        end
        if (state_reg == tlfd_pkg::ST_READ_WAIT)
            out_reg <= (32'(ra_reg) < CANVAS_ROWS && 32'(ca_reg) < CANVAS_COLS)
                       ? rd_data_reg : '0;
    end

    assign m_tvalid = (state_reg == tlfd_pkg::ST_OUT);
    assign m_tdata  = {out_reg[7:0], out_reg[15:8], out_reg[23:16]};

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == tlfd_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == tlfd_pkg::ST_READ_WAIT)
        else $error("result without read");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (au_ctrl.start_div || au_ctrl.start_sqrt) |-> !au_busy)
        else $error("unit restarted while busy");
`endif

endmodule

// File: rtl/core/tlfd_arith.sv
// ----------------------------------------------------------------------------
// tlfd_arith
// shared restoring divider and integer square root, one bit per cycle
// ----------------------------------------------------------------------------
module tlfd_arith
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  tlfd_pkg::au_ctrl_t                  ctrl,
    input  logic [tlfd_pkg::NumW-1:0]           op_a,
    input  logic [tlfd_pkg::SumW-1:0]           op_b,
    output logic                                busy,
    output logic [tlfd_pkg::QuoW-1:0]           result
);

    localparam int unsigned NumW = tlfd_pkg::NumW;
    localparam int unsigned QuoW = tlfd_pkg::QuoW;
    localparam int unsigned CntW = 6;

    logic            busy_reg, busy_next;
    logic            is_sqrt_reg, is_sqrt_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [NumW-1:0] x_reg, x_next;      // dividend shift reg or radicand
    logic [NumW:0]   rem_reg, rem_next;  // divider remainder
    logic [QuoW-1:0] q_reg, q_next;
    logic [NumW+1:0] rrem_reg, rrem_next; // root remainder
    logic [NumW:0]   trial;
    logic [NumW+1:0] rtrial;

    always_comb
    begin
        busy_next    = busy_reg;
        is_sqrt_next = is_sqrt_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        rrem_next    = rrem_reg;
        trial        = '0;
        rtrial       = '0;
        if (ctrl.start_div)
        begin
            busy_next    = 1'b1;
            is_sqrt_next = 1'b0;
            cnt_next     = CntW'(NumW);
            x_next       = op_a;
            rem_next     = '0;
            q_next       = '0;
        end
        else if (ctrl.start_sqrt)
        begin
            busy_next    = 1'b1;
            is_sqrt_next = 1'b1;
            cnt_next     = CntW'(NumW / 2);
            // shift by one so the bit pairs line up with bit 0 of the radicand
            x_next       = {op_a[NumW-2:0], 1'b0};
            rrem_next    = '0;
            q_next       = '0;
        end
        else if (busy_reg)
        begin
            if (!is_sqrt_reg)
            begin
                trial = {rem_reg[NumW-1:0], x_reg[NumW-1]};
                x_next = {x_reg[NumW-2:0], 1'b0};
                if (trial >= {{(NumW+1-tlfd_pkg::SumW){1'b0}}, op_b})
                begin
                    rem_next = trial - {{(NumW+1-tlfd_pkg::SumW){1'b0}}, op_b};
                    q_next   = {q_reg[QuoW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    q_next   = {q_reg[QuoW-2:0], 1'b0};
                end
            end
            else
            begin
                // two bits of radicand per step
                rtrial = {rrem_reg[NumW-1:0], x_reg[NumW-1:NumW-2]};
                x_next = {x_reg[NumW-3:0], 2'b00};
                if (rtrial >= {{(NumW+2-QuoW-2){1'b0}}, q_reg, 2'b01})
                begin
                    rrem_next = rtrial - {{(NumW+2-QuoW-2){1'b0}}, q_reg, 2'b01};
                    q_next    = {q_reg[QuoW-2:0], 1'b1};
                end
                else
                begin
                    rrem_next = rtrial;
                    q_next    = {q_reg[QuoW-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_sqrt_reg <= is_sqrt_next;
        x_reg       <= x_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        rrem_reg    <= rrem_next;
    end

    assign busy   = busy_reg;
    // quotient or root
    assign result = q_reg;

endmodule
